// ===== rtl/core/running_average_background_subtractor_defines.svh =====
// Assertion macros for the background subtractor RTL.
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACTOR_DEFINES_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACTOR_DEFINES_SVH

// same-cycle implication
`define RABS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rabs: assertion failed");

// next-cycle implication
`define RABS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rabs: assertion failed");

`endif

// ===== rtl/core/rabs_pkg.sv =====
// Types and constants for the running-average background subtractor.
package rabs_pkg;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [15:0] OLD_WEIGHT_RST = 16'd62259;
  localparam logic [15:0] NEW_WEIGHT_RST = 16'd3277;
  localparam logic [8:0]  THRESHOLD_RST  = 9'd20;

  typedef enum logic [1:0] {
    REG_OLD_WEIGHT = 2'd0,
    REG_NEW_WEIGHT = 2'd1,
    REG_THRESHOLD  = 2'd2
  } rabs_reg_t;

  typedef struct packed {
    logic [15:0] old_weight;
    logic [15:0] new_weight;
    logic [8:0]  threshold;
  } rabs_cfg_t;

endpackage

// ===== rtl/core/rabs_regs.sv =====
// APB configuration registers of the background subtractor.
module rabs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rabs_pkg::PADDR_W-1:0]  paddr,
  input  logic [rabs_pkg::PDATA_W-1:0]  pwdata,
  output logic [rabs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output rabs_pkg::rabs_cfg_t           cfg
);
  import rabs_pkg::*;

  rabs_reg_t reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = rabs_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.old_weight <= OLD_WEIGHT_RST;
      cfg.new_weight <= NEW_WEIGHT_RST;
      cfg.threshold  <= THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_OLD_WEIGHT: cfg.old_weight <= pwdata[15:0];
        REG_NEW_WEIGHT: cfg.new_weight <= pwdata[15:0];
        REG_THRESHOLD:  cfg.threshold  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_OLD_WEIGHT: prdata = {16'd0, cfg.old_weight};
      REG_NEW_WEIGHT: prdata = {16'd0, cfg.new_weight};
      REG_THRESHOLD:  prdata = {23'd0, cfg.threshold};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/running_average_background_subtractor.sv =====
// Running-average background subtractor: one grey pixel in, one foreground result out.
//
// Accepts one pixel per clock while pixel_stall is low; each pixel passes through the
// read stage, the blend stage and the output register. The background store is a
// single-port-write, registered-read memory: a pixel's entry is read as it is accepted
// and written back from the blend stage, as its result enters the output register.
// A new pixel whose address matches one still being updated (frames of one or two
// pixels) is held off by pixel_stall until that write lands. The store is not cleared
// after reset; the first frame seeds every entry it covers, and a later frame must not
// be longer than the first.
module running_average_background_subtractor #(
  parameter int MAX_FRAME_PIXELS = 131072
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [7:0]                    pixel,
  input  logic                          last_in_frame,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          foreground,
  output logic [7:0]                    background_value,
  output logic                          frame_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rabs_pkg::PADDR_W-1:0]  paddr,
  input  logic [rabs_pkg::PDATA_W-1:0]  pwdata,
  output logic [rabs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import rabs_pkg::*;
  `include "running_average_background_subtractor_defines.svh"

  localparam int AW = $clog2(MAX_FRAME_PIXELS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FRAME_PIXELS - 1);

  rabs_cfg_t cfg;

  rabs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [7:0] store [MAX_FRAME_PIXELS];
  logic [7:0] mem_q;

  logic [AW-1:0] pixel_address;
  logic          first_frame;

  // read stage
  logic          a_valid;
  logic [AW-1:0] a_addr;
  logic [7:0]    a_pix;
  logic          a_last;
  logic          a_first;

  // blend stage
  logic          b_valid;
  logic [AW-1:0] b_addr;
  logic [7:0]    b_old;
  logic          b_fg;
  logic          b_last;
  logic [23:0]   b_prod_old;
  logic [23:0]   b_prod_new;

  logic rdy_out, rdy_b, rdy_a, hazard, in_acc;

  logic [7:0]  a_old, a_diff;
  logic        a_below;
  logic [24:0] b_sum;
  logic [7:0]  b_newbg;

  assign rdy_out     = !result_valid || !result_stall;
  assign rdy_b       = !b_valid || rdy_out;
  assign rdy_a       = !a_valid || rdy_b;
  assign hazard      = (a_valid && a_addr == pixel_address) ||
                       (b_valid && b_addr == pixel_address);
  assign pixel_stall = !rdy_a || hazard;
  assign in_acc      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_address <= '0;
      first_frame   <= 1'b1;
    end else if (in_acc) begin
      if (last_in_frame) begin
        pixel_address <= '0;
        first_frame   <= 1'b0;
      end else if (pixel_address == LAST_ADDR) begin
        pixel_address <= '0;
      end else begin
        pixel_address <= pixel_address + AW'(1);
      end
    end
  end

  // background store
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_q <= store[pixel_address];
    end
    if (b_valid && rdy_out) begin
      store[b_addr] <= b_newbg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (rdy_a) begin
      a_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_addr  <= pixel_address;
      a_pix   <= pixel;
      a_last  <= last_in_frame;
      a_first <= first_frame;
    end
  end

  always_comb begin
    a_old   = a_first ? a_pix : mem_q;
    a_diff  = (a_old > a_pix) ? (a_old - a_pix) : (a_pix - a_old);
    a_below = {1'b0, a_diff} < cfg.threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (rdy_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && rdy_b) begin
      b_addr     <= a_addr;
      b_old      <= a_old;
      b_fg       <= !a_below;
      b_last     <= a_last;
      b_prod_old <= 24'(cfg.old_weight) * 24'(a_old);
      b_prod_new <= 24'(cfg.new_weight) * 24'(a_pix);
    end
  end

  always_comb begin
    b_sum   = {1'b0, b_prod_old} + {1'b0, b_prod_new};
    b_newbg = b_fg ? b_old : (b_sum[24] ? 8'hFF : b_sum[23:16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (rdy_out) begin
      result_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && rdy_out) begin
      foreground       <= b_fg;
      background_value <= b_newbg;
      frame_end        <= b_last;
    end
  end

  `RABS_ASSERT_IMPL(a_no_addr_clash, a_valid && b_valid, a_addr != b_addr)
  `RABS_ASSERT_NEXT(a_frame_restart, in_acc && last_in_frame, pixel_address == '0)
  `RABS_ASSERT_IMPL(a_addr_in_range, 1'b1, pixel_address <= LAST_ADDR)

endmodule
